### sv/slcd_pkg.sv
`default_nettype none
package slcd_pkg;

  // Segment image geometry: 128 segment bits held as eight 16-bit words.
  localparam int unsigned IMAGE_WORDS = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned WIDX_W      = $clog2(IMAGE_WORDS);

  // Chunk lengths on the wire.
  localparam logic [4:0] LEN_FLUSH_HDR = 5'd9;
  localparam logic [4:0] LEN_COMMAND   = 5'd12;
  localparam logic [4:0] LEN_NIBBLE    = 5'd13;
  localparam logic [4:0] LEN_WORD      = 5'd16;
  localparam logic [4:0] LEN_HEADER    = 5'd3;
  localparam logic [4:0] LEN_CMD_BYTE  = 5'd8;
  localparam logic [4:0] LEN_ADDR      = 5'd6;
  localparam logic [4:0] LEN_DATA      = 5'd4;

  // Header bits, first wire bit in bit 0.
  localparam logic [2:0] HDR_WRITE   = 3'b101;
  localparam logic [2:0] HDR_COMMAND = 3'b001;

  localparam logic [15:0] KEEP_SPLIT_HI = 16'hfff1;
  localparam logic [15:0] KEEP_SPLIT_LO = 16'h0fff;
  localparam logic [15:0] KEEP_MID      = 16'hf10f;
  localparam logic [15:0] KEEP_HIGH     = 16'h10ff;
  localparam logic [15:0] KEEP_LOW      = 16'hff10;

  localparam logic [3:0] GLYPH_DASH = 4'd10;

  typedef enum logic [2:0] {
    OP_SET_DIGIT = 3'd0,
    OP_SET_SEG   = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_FLUSH     = 3'd3,
    OP_COMMAND   = 3'd4,
    OP_NIBBLE    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    FK_FLUSH   = 2'd0,
    FK_COMMAND = 2'd1,
    FK_NIBBLE  = 2'd2
  } frame_kind_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_HDR  = 3'd1,
    S_MSB  = 3'd2,
    S_LSB  = 3'd3,
    S_TAIL = 3'd4,
    S_DONE = 3'd5
  } ser_state_t;

  // Image edit request, valid for one cycle on an accepted transaction.
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [3:0] value;
    logic [3:0] pos;
    logic [6:0] seg;
    logic       show;
  } edit_req_t;

  // Frame start request for the serialiser.
  typedef struct packed {
    logic        valid;
    frame_kind_t kind;
    logic [7:0]  cmd;
    logic [5:0]  addr;
    logic [3:0]  data;
  } frame_req_t;

  // One digit touches at most two image words.
  typedef struct packed {
    logic              a_en;
    logic [WIDX_W-1:0] a_word;
    logic [15:0]       a_keep;
    logic [15:0]       a_set;
    logic              b_en;
    logic [WIDX_W-1:0] b_word;
    logic [15:0]       b_keep;
    logic [15:0]       b_set;
  } digit_edit_t;

  function automatic logic [7:0] glyph(input logic [3:0] value);
    logic [7:0] g;
    begin
      unique case (value)
        4'd0:    g = 8'haf;
        4'd1:    g = 8'h06;
        4'd2:    g = 8'h6d;
        4'd3:    g = 8'h4f;
        4'd4:    g = 8'hc6;
        4'd5:    g = 8'hcb;
        4'd6:    g = 8'heb;
        4'd7:    g = 8'h0e;
        4'd8:    g = 8'hef;
        4'd9:    g = 8'hcf;
        4'd10:   g = 8'h40;
        default: g = 8'h00;
      endcase
      return g;
    end
  endfunction

  function automatic digit_edit_t digit_edit(input logic [3:0] value, input logic [3:0] pos,
                                             input logic show);
    digit_edit_t e;
    logic [7:0]  c;
    logic [15:0] split_hi;
    logic [15:0] split_lo;
    begin
      c = (show && value <= GLYPH_DASH) ? glyph(value) : 8'h00;
      split_hi = {12'h000, c[7:4]};
      split_lo = {c[3:0], 12'h000};
      e = '0;
      unique case (pos)
        4'd0: e = {1'b1, 3'd2, KEEP_SPLIT_HI, split_hi, 1'b1, 3'd1, KEEP_SPLIT_LO, split_lo};
        4'd1: e = {1'b1, 3'd1, KEEP_MID, {4'h0, c, 4'h0}, 1'b0, 3'd0, 16'h0, 16'h0};
        4'd2: e = {1'b1, 3'd1, KEEP_SPLIT_HI, split_hi, 1'b1, 3'd0, KEEP_SPLIT_LO, split_lo};
        4'd3: e = {1'b1, 3'd5, KEEP_HIGH, {c, 8'h00}, 1'b0, 3'd0, 16'h0, 16'h0};
        4'd4: e = {1'b1, 3'd5, KEEP_LOW, {8'h00, c}, 1'b0, 3'd0, 16'h0, 16'h0};
        4'd5: e = {1'b1, 3'd4, KEEP_HIGH, {c, 8'h00}, 1'b0, 3'd0, 16'h0, 16'h0};
        4'd6: e = {1'b1, 3'd4, KEEP_SPLIT_HI, split_hi, 1'b1, 3'd3, KEEP_SPLIT_LO, split_lo};
        4'd7: e = {1'b1, 3'd3, KEEP_MID, {4'h0, c, 4'h0}, 1'b0, 3'd0, 16'h0, 16'h0};
        4'd8: e = {1'b1, 3'd3, KEEP_SPLIT_HI, split_hi, 1'b1, 3'd2, KEEP_SPLIT_LO, split_lo};
        4'd9: e = {1'b1, 3'd2, KEEP_MID, {4'h0, c, 4'h0}, 1'b0, 3'd0, 16'h0, 16'h0};
        default: e = '0;
      endcase
      return e;
    end
  endfunction

endpackage
`default_nettype wire

### sv/segment_lcd_buffer_and_serializer_core.sv
// Segment LCD image buffer and serial frame generator.
// The input stream (in_*) carries one operation per transaction: the operation code travels
// in in_tuser, its arguments in in_tdata. Digit, segment and clear operations edit the
// 128-bit segment image in the cycle after acceptance and produce no output. Flush, command
// and nibble-write operations produce a frame on the output stream (out_*) as chunks of wire
// bits, bit 0 first, with the bit count alongside and tlast on the final chunk of a frame;
// chip select is meant to rise after that chunk.
// Frames are assembled one wire bit per clock in a shift register; a flush frame carries
// a 9-bit header and eight 16-bit words. The next operation is accepted once the last
// chunk of a frame has moved into the output register, even while that chunk still waits
// for the receiver; image edits are taken whenever the assembler is idle, one per cycle.
// When the receiver stalls, the output register holds its chunk and the assembler waits
// with the next chunk complete, so no bits are lost or repeated.
// Reset (synchronous, active low) clears the image to all zeros, empties the output
// register and returns the assembler to idle; the block is ready in the next cycle.
`default_nettype none
module segment_lcd_buffer_and_serializer_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: digit_value[3:0], digit_position[3:0], segment_index[6:0], show,
  // command_code[7:0], nibble_address[5:0], nibble_data[3:0], zero padding.
  input  wire  [39:0] in_tdata,
  // in_tuser: operation[2:0].
  input  wire  [2:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_tdata, from bit 0: frame_bits[15:0], bit_count[4:0], zero padding.
  output logic [23:0] out_tdata,
  output logic        out_tlast
);
  import slcd_pkg::*;

  logic              accept;
  op_t               op;
  edit_req_t         edit;
  frame_req_t        freq;
  logic              ser_idle;
  logic [WIDX_W-1:0] rd_idx;
  logic [15:0]       rd_word;
  logic [15:0]       frame_bits;
  logic [4:0]        bit_count;

  assign in_tready = ser_idle;
  assign accept    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);

  // Edits go straight to the image; operations six and seven fall through and do nothing.
  always_comb begin
    edit.valid = accept;
    edit.op    = op;
    edit.value = in_tdata[3:0];
    edit.pos   = in_tdata[7:4];
    edit.seg   = in_tdata[14:8];
    edit.show  = in_tdata[15];
  end

  always_comb begin
    freq.cmd  = in_tdata[23:16];
    freq.addr = in_tdata[29:24];
    freq.data = in_tdata[33:30];
    unique case (op)
      OP_FLUSH: begin
        freq.valid = accept;
        freq.kind  = FK_FLUSH;
      end
      OP_COMMAND: begin
        freq.valid = accept;
        freq.kind  = FK_COMMAND;
      end
      OP_NIBBLE: begin
        freq.valid = accept;
        freq.kind  = FK_NIBBLE;
      end
      default: begin
        freq.valid = 1'b0;
        freq.kind  = FK_FLUSH;
      end
    endcase
  end

  slcd_image u_image (
    .clk     (clk),
    .rst_n   (rst_n),
    .edit    (edit),
    .rd_idx  (rd_idx),
    .rd_word (rd_word)
  );

  slcd_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (freq),
    .idle      (ser_idle),
    .rd_idx    (rd_idx),
    .rd_word   (rd_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bits  (frame_bits),
    .out_count (bit_count),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, bit_count, frame_bits};

endmodule
`default_nettype wire

### sv/slcd_image.sv
`default_nettype none
module slcd_image (
  input  wire                       clk,
  input  wire                       rst_n,
  input  slcd_pkg::edit_req_t       edit,
  input  wire [slcd_pkg::WIDX_W-1:0] rd_idx,
  output logic [15:0]               rd_word
);
  import slcd_pkg::*;

  logic [15:0] img_r   [IMAGE_WORDS];
  logic [15:0] img_nxt [IMAGE_WORDS];
  digit_edit_t de;

  assign de      = digit_edit(edit.value, edit.pos, edit.show);
  assign rd_word = img_r[rd_idx];

  // Each word works out its own next value.
  always_comb begin
    for (int w = 0; w < IMAGE_WORDS; w++) begin
      img_nxt[w] = img_r[w];
      if (edit.valid) begin
        unique case (edit.op)
          OP_SET_DIGIT: begin
            if (de.a_en && de.a_word == WIDX_W'(w)) begin
              img_nxt[w] = (img_r[w] & de.a_keep) | de.a_set;
            end
            if (de.b_en && de.b_word == WIDX_W'(w)) begin
              img_nxt[w] = (img_r[w] & de.b_keep) | de.b_set;
            end
          end
          OP_SET_SEG: begin
            if (edit.seg[6:4] == WIDX_W'(w)) begin
              img_nxt[w][edit.seg[3:0]] = edit.show;
            end
          end
          OP_CLEAR: begin
            img_nxt[w] = '0;
          end
          default: begin
            img_nxt[w] = img_r[w];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < IMAGE_WORDS; w++) begin
      if (!rst_n) begin
        img_r[w] <= '0;
      end else begin
        img_r[w] <= img_nxt[w];
      end
    end
  end

endmodule
`default_nettype wire

### sv/slcd_ser.sv
`default_nettype none
module slcd_ser (
  input  wire                        clk,
  input  wire                        rst_n,
  input  slcd_pkg::frame_req_t       req,
  output logic                       idle,
  output logic [slcd_pkg::WIDX_W-1:0] rd_idx,
  input  wire  [15:0]                rd_word,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [15:0]                out_bits,
  output logic [4:0]                 out_count,
  output logic                       out_last
);
  import slcd_pkg::*;

  ser_state_t        state_r, state_nxt;
  frame_kind_t       kind_r, kind_nxt;
  logic [2:0]        hdr_r, hdr_nxt;
  logic [15:0]       sh_r, sh_nxt;
  logic [4:0]        left_r, left_nxt;
  logic [15:0]       asm_r, asm_nxt;
  logic              tail_r, tail_nxt;
  logic [3:0]        nd_r, nd_nxt;
  logic [4:0]        len_r, len_nxt;
  logic [WIDX_W-1:0] idx_r, idx_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [15:0]       obits_r, obits_nxt;
  logic [4:0]        ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;

  logic        slot_free;
  logic        last_step;
  logic        wire_bit;
  logic        chunk_last;
  logic [15:0] aligned;

  assign slot_free  = !ovalid_r || out_ready;
  assign last_step  = (left_r == 5'd1);
  assign idle       = (state_r == S_IDLE);
  assign rd_idx     = (len_r == LEN_FLUSH_HDR) ? '0 : idx_r + 1'b1;
  assign chunk_last = (kind_r != FK_FLUSH) ||
                      (len_r == LEN_WORD && idx_r == WIDX_W'(IMAGE_WORDS - 1));

  assign out_valid = ovalid_r;
  assign out_bits  = obits_r;
  assign out_count = ocnt_r;
  assign out_last  = olast_r;

  // The assembled bits sit at the top of asm_r; move them down to bit 0.
  always_comb begin
    unique case (len_r)
      LEN_FLUSH_HDR: aligned = asm_r >> 7;
      LEN_COMMAND:   aligned = asm_r >> 4;
      LEN_NIBBLE:    aligned = asm_r >> 3;
      default:       aligned = asm_r;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_HDR:   wire_bit = hdr_r[0];
      S_MSB:   wire_bit = sh_r[15];
      S_LSB:   wire_bit = sh_r[0];
      S_TAIL:  wire_bit = tail_r;
      default: wire_bit = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req.valid) state_nxt = S_HDR;
      S_HDR:  if (last_step) state_nxt = S_MSB;
      S_MSB: begin
        if (last_step) begin
          priority case (kind_r)
            FK_COMMAND: state_nxt = S_TAIL;
            FK_NIBBLE:  state_nxt = S_LSB;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_LSB:  if (last_step) state_nxt = S_DONE;
      S_TAIL: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) state_nxt = chunk_last ? S_IDLE : S_LSB;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    kind_nxt   = kind_r;
    hdr_nxt    = hdr_r;
    sh_nxt     = sh_r;
    left_nxt   = left_r;
    asm_nxt    = asm_r;
    tail_nxt   = tail_r;
    nd_nxt     = nd_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    ovalid_nxt = out_ready ? 1'b0 : ovalid_r;
    obits_nxt  = obits_r;
    ocnt_nxt   = ocnt_r;
    olast_nxt  = olast_r;

    if (state_r == S_HDR || state_r == S_MSB || state_r == S_LSB || state_r == S_TAIL) begin
      asm_nxt  = {wire_bit, asm_r[15:1]};
      left_nxt = left_r - 5'd1;
      hdr_nxt  = {1'b0, hdr_r[2:1]};
      if (state_r == S_MSB) sh_nxt = {sh_r[14:0], 1'b0};
      if (state_r == S_LSB) sh_nxt = {1'b0, sh_r[15:1]};
    end

    unique case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          kind_nxt = req.kind;
          tail_nxt = req.cmd[0];
          nd_nxt   = req.data;
          left_nxt = LEN_HEADER;
          idx_nxt  = '0;
          priority case (req.kind)
            FK_COMMAND: begin
              hdr_nxt = HDR_COMMAND;
              sh_nxt  = {req.cmd, 8'h00};
            end
            FK_NIBBLE: begin
              hdr_nxt = HDR_WRITE;
              sh_nxt  = {req.addr, 10'h000};
            end
            default: begin
              hdr_nxt = HDR_WRITE;
              sh_nxt  = '0;
            end
          endcase
        end
      end
      S_HDR: begin
        if (last_step) left_nxt = (kind_r == FK_COMMAND) ? LEN_CMD_BYTE : LEN_ADDR;
      end
      S_MSB: begin
        if (last_step) begin
          priority case (kind_r)
            FK_COMMAND: left_nxt = 5'd1;
            FK_NIBBLE: begin
              left_nxt = LEN_DATA;
              sh_nxt   = {12'h000, nd_r};
            end
            default: len_nxt = LEN_FLUSH_HDR;
          endcase
        end
      end
      S_LSB: begin
        if (last_step) len_nxt = (kind_r == FK_NIBBLE) ? LEN_NIBBLE : LEN_WORD;
      end
      S_TAIL: begin
        len_nxt = LEN_COMMAND;
      end
      S_DONE: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          obits_nxt  = aligned;
          ocnt_nxt   = len_r;
          olast_nxt  = chunk_last;
          if (chunk_last) begin
            idx_nxt = '0;
          end else begin
            idx_nxt  = rd_idx;
            sh_nxt   = rd_word;
            left_nxt = LEN_WORD;
          end
        end
      end
      default: begin
        left_nxt = left_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
      len_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
      len_r    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    hdr_r   <= hdr_nxt;
    sh_r    <= sh_nxt;
    left_r  <= left_nxt;
    asm_r   <= asm_nxt;
    tail_r  <= tail_nxt;
    nd_r    <= nd_nxt;
    obits_r <= obits_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

endmodule
`default_nettype wire

### verif/tb_segment_lcd_buffer_and_serializer_core.sv
`timescale 1ns / 1ps

import slcd_pkg::*;

// One operation as it travels on the input stream, fields in the order of the work they do.
typedef struct packed {
  logic [2:0] op;
  logic [3:0] value;
  logic [3:0] pos;
  logic [6:0] seg;
  logic       show;
  logic [7:0] cmd;
  logic [5:0] addr;
  logic [3:0] data;
} lcd_request_t;

// One chunk of wire bits as the output stream should carry it.
typedef struct packed {
  logic [15:0] bits;
  logic [4:0]  count;
  logic        last;
} wire_chunk_t;

class lcd_frame_scoreboard;
  logic [15:0] image [IMAGE_WORDS];
  wire_chunk_t expected_chunks [$];
  int unsigned mismatches;
  int unsigned chunks_checked;
  int unsigned flushes;
  int unsigned commands;
  int unsigned nibble_writes;
  int unsigned edits;

  function new();
    foreach (image[i]) image[i] = '0;
    mismatches     = 0;
    chunks_checked = 0;
    flushes        = 0;
    commands       = 0;
    nibble_writes  = 0;
    edits          = 0;
  endfunction

  function logic [7:0] glyph_of(input logic [3:0] v);
    logic [7:0] rom [11];
    rom = '{8'haf, 8'h06, 8'h6d, 8'h4f, 8'hc6, 8'hcb, 8'heb, 8'h0e, 8'hef, 8'hcf, 8'h40};
    return (v <= GLYPH_DASH) ? rom[v] : 8'h00;
  endfunction

  // A digit split across two words: high glyph nibble low in one, low nibble on top of the other.
  function void split_digit(input int hi, input int lo, input logic [7:0] code);
    image[hi] = (image[hi] & KEEP_SPLIT_HI) | {12'h000, code[7:4]};
    image[lo] = (image[lo] & KEEP_SPLIT_LO) | {code[3:0], 12'h000};
  endfunction

  function void masked_digit(input int w, input logic [15:0] keep, input int shift,
                             input logic [7:0] code);
    image[w] = (image[w] & keep) | (16'(code) << shift);
  endfunction

  function void write_digit(input logic [3:0] value, input logic [3:0] pos, input logic show);
    logic [7:0] code;
    code = show ? glyph_of(value) : 8'h00;
    case (pos)
      4'd0: split_digit(2, 1, code);
      4'd1: masked_digit(1, KEEP_MID, 4, code);
      4'd2: split_digit(1, 0, code);
      4'd3: masked_digit(5, KEEP_HIGH, 8, code);
      4'd4: masked_digit(5, KEEP_LOW, 0, code);
      4'd5: masked_digit(4, KEEP_HIGH, 8, code);
      4'd6: split_digit(4, 3, code);
      4'd7: masked_digit(3, KEEP_MID, 4, code);
      4'd8: split_digit(3, 2, code);
      4'd9: masked_digit(2, KEEP_MID, 4, code);
      default: ;
    endcase
  endfunction

  function void expect_chunk(input logic [15:0] bits, input logic [4:0] count, input logic last);
    wire_chunk_t c;
    c.bits  = bits;
    c.count = count;
    c.last  = last;
    expected_chunks.push_back(c);
  endfunction

  function void note_request(input lcd_request_t r);
    logic [15:0] bits;
    case (r.op)
      OP_SET_DIGIT: begin
        write_digit(r.value, r.pos, r.show);
        edits++;
      end
      OP_SET_SEG: begin
        if (r.show) image[r.seg[6:4]] |= 16'd1 << r.seg[3:0];
        else image[r.seg[6:4]] &= ~(16'd1 << r.seg[3:0]);
        edits++;
      end
      OP_CLEAR: begin
        foreach (image[i]) image[i] = '0;
        edits++;
      end
      OP_FLUSH: begin
        expect_chunk({13'h0000, HDR_WRITE}, LEN_FLUSH_HDR, 1'b0);
        for (int i = 0; i < IMAGE_WORDS; i++)
          expect_chunk(image[i], LEN_WORD, i == IMAGE_WORDS - 1);
        flushes++;
      end
      OP_COMMAND: begin
        bits = {13'h0000, HDR_COMMAND};
        for (int i = 0; i < 8; i++) bits[3 + i] = r.cmd[7 - i];
        bits[11] = r.cmd[0];
        expect_chunk(bits, LEN_COMMAND, 1'b1);
        commands++;
      end
      OP_NIBBLE: begin
        bits = {13'h0000, HDR_WRITE};
        for (int i = 0; i < 6; i++) bits[3 + i] = r.addr[5 - i];
        bits[12:9] = r.data;
        expect_chunk(bits, LEN_NIBBLE, 1'b1);
        nibble_writes++;
      end
      default: ;
    endcase
  endfunction

  function void report(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] chunk %0d: %s", $realtime, chunks_checked, what);
  endfunction

  function void check_chunk(input logic [23:0] tdata, input logic tlast);
    wire_chunk_t want;
    chunks_checked++;
    if (expected_chunks.size() == 0) begin
      report($sformatf("unexpected chunk, bits %h count %0d last %b",
                       tdata[15:0], tdata[20:16], tlast));
      return;
    end
    want = expected_chunks.pop_front();
    if (tdata[15:0] !== want.bits)
      report($sformatf("frame bits expected %h, got %h", want.bits, tdata[15:0]));
    if (tdata[20:16] !== want.count)
      report($sformatf("bit count expected %0d, got %0d", want.count, tdata[20:16]));
    if (tdata[23:21] !== 3'b000)
      report($sformatf("padding expected 0, got %b", tdata[23:21]));
    if (tlast !== want.last)
      report($sformatf("last flag expected %b, got %b", want.last, tlast));
  endfunction

  function int pending();
    return expected_chunks.size();
  endfunction
endclass

module tb_segment_lcd_buffer_and_serializer_core;

  localparam int unsigned RANDOM_ITEMS = 200;
  // The slowest correct run stays well under this limit (flush-heavy stimulus, full stalls).
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Operation codes that the block does not use and must swallow silently.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // When set, the sender or the receiver stops inserting idle cycles.
  bit          src_calm;
  bit          sink_calm;
  int unsigned cycle_count = 0;

  lcd_frame_scoreboard sb;

  segment_lcd_buffer_and_serializer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // A hung handshake or a lost chunk ends up here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped at the cycle limit with %0d chunks still expected.", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Random operation, weighted towards runs of image edits followed by a flush so that the
  // flushed image reflects long edit histories. Every field is random, used or not, so that
  // the block is also seen to ignore the fields an operation does not need.
  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.op = OP_SET_DIGIT;
    else if (pick < 60) r.op = OP_SET_SEG;
    else if (pick < 64) r.op = OP_CLEAR;
    else if (pick < 80) r.op = OP_FLUSH;
    else if (pick < 88) r.op = OP_COMMAND;
    else if (pick < 97) r.op = OP_NIBBLE;
    else r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    r.value = 4'($urandom_range(0, 15));
    // Mostly real digit places; the rest must leave the image alone.
    r.pos   = 4'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 9) : $urandom_range(10, 15));
    r.seg   = 7'($urandom_range(0, 127));
    r.show  = 1'($urandom_range(0, 1));
    r.cmd   = 8'($urandom_range(0, 255));
    r.addr  = 6'($urandom_range(0, 63));
    r.data  = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Presents one operation and waits for its transaction. Called and returns at a falling
  // edge; valid is only lowered when an idle gap is drawn, so back-to-back operations keep
  // it high without a glitch.
  task automatic send_request(input lcd_request_t r);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= r.op;
    in_tdata  <= {6'h00, r.data, r.addr, r.cmd, r.show, r.seg, r.pos, r.value};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Holds the sender back, with valid low, until every predicted chunk has been received.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Receiver: draws a stall before each chunk, then holds tready high until a transaction
  // completes. The chunk is checked at the rising edge on which it is taken.
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_chunk(out_tdata, out_tlast);
      @(negedge clk);
    end
  end

  initial begin
    lcd_request_t r;
    int unsigned  counted;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A flush straight after reset must show a blank image.
    send_request('{OP_FLUSH, 4'h3, 4'h2, 7'h11, 1'b1, 8'h5a, 6'h15, 4'h6});
    // Every digit at its own place, with show set only for the odd ones, then a flush to see the whole pattern.
    for (int d = 0; d < 10; d++)
      send_request('{OP_SET_DIGIT, 4'(d), 4'(d), 7'(d * 13), 1'(d), 8'(d * 29), 6'(d * 7), 4'(d)});
    send_request('{OP_FLUSH, 4'hf, 4'hf, 7'h7f, 1'b0, 8'hff, 6'h3f, 4'hf});
    // The dash glyph, a blank glyph with show set, a place beyond the last digit, and
    // a digit blanked by show being low.
    send_request('{OP_SET_DIGIT, GLYPH_DASH, 4'd3, 7'h00, 1'b1, 8'h00, 6'h00, 4'h0});
    send_request('{OP_SET_DIGIT, 4'd15, 4'd1, 7'h7f, 1'b1, 8'hff, 6'h3f, 4'hf});
    send_request('{OP_SET_DIGIT, 4'd8, 4'd15, 7'h2a, 1'b1, 8'h81, 6'h21, 4'h9});
    send_request('{OP_SET_DIGIT, 4'd8, 4'd6, 7'h55, 1'b0, 8'h7e, 6'h1e, 4'h6});
    // Top and bottom segment bits.
    send_request('{OP_SET_SEG, 4'h0, 4'h0, 7'd127, 1'b1, 8'h00, 6'h00, 4'h0});
    send_request('{OP_SET_SEG, 4'hf, 4'hf, 7'd0, 1'b1, 8'hff, 6'h3f, 4'hf});
    // An unused operation code must produce nothing and leave the image as it is.
    send_request('{OP_SPARE_B, 4'h8, 4'h0, 7'h40, 1'b1, 8'h3c, 6'h2d, 4'ha});
    send_request('{OP_FLUSH, 4'h0, 4'h0, 7'h00, 1'b0, 8'h00, 6'h00, 4'h0});
    // Command and nibble-write frames at the extremes of their fields.
    send_request('{OP_COMMAND, 4'hf, 4'hf, 7'h7f, 1'b1, 8'hff, 6'h3f, 4'hf});
    send_request('{OP_COMMAND, 4'h0, 4'h0, 7'h00, 1'b0, 8'h00, 6'h00, 4'h0});
    send_request('{OP_NIBBLE, 4'h0, 4'h0, 7'h00, 1'b0, 8'h00, 6'h3f, 4'hf});
    send_request('{OP_NIBBLE, 4'hf, 4'hf, 7'h7f, 1'b1, 8'hff, 6'h00, 4'h0});
    // Let the output side run dry before the image is cleared and flushed once more.
    drain_results();
    send_request('{OP_CLEAR, 4'h8, 4'h0, 7'h7f, 1'b1, 8'ha5, 6'h2a, 4'h5});
    send_request('{OP_FLUSH, 4'h1, 4'h9, 7'h01, 1'b1, 8'h01, 6'h01, 4'h1});

    // Random part. The idling pattern rotates every forty operations between both sides
    // idling, neither idling, and one side idling alone; every sixty operations the sender
    // waits for the output to empty completely.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      case ((counted / 40) % 4)
        0: begin src_calm = 1'b0; sink_calm = 1'b0; end
        1: begin src_calm = 1'b1; sink_calm = 1'b1; end
        2: begin src_calm = 1'b1; sink_calm = 1'b0; end
        default: begin src_calm = 1'b0; sink_calm = 1'b1; end
      endcase
      if (counted % 60 == 59) drain_results();
      r = random_request();
      send_request(r);
      if (r.op <= OP_NIBBLE) counted++;
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;

    // Wait for the last frame, then long enough for a full flush so that any stray chunk
    // would still be caught.
    drain_results();
    repeat (200) @(negedge clk);

    $display("Covered %0d image edits, %0d flushes, %0d command and %0d nibble-write frames,",
             sb.edits, sb.flushes, sb.commands, sb.nibble_writes);
    $display("with idle gaps and stalls on both streams: %0d chunks checked, %0d mismatches.",
             sb.chunks_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
